/* hdl/hsac_pkg.sv */
// Package for the heap shadow access checker: sizes, codes and transfer types.
package hsac_pkg;

    // Heap size in bytes and shadow marks packed into one storage word.
    // MARKS_PER_WORD must be a power of two, at least 2.
    localparam int HEAP_BYTES     = 65536;
    localparam int MARKS_PER_WORD = 32;
    localparam int SHADOW_WORDS   = (HEAP_BYTES + MARKS_PER_WORD - 1) / MARKS_PER_WORD;

    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 17;
    localparam int OFF_W   = $clog2(HEAP_BYTES);
    localparam int BIT_W   = $clog2(MARKS_PER_WORD);
    localparam int WADDR_W = $clog2(SHADOW_WORDS);
    localparam int END_W   = ((OFF_W > LEN_W) ? OFF_W : LEN_W) + 1;

    // Request codes; codes 2 and 3 both decode as a check.
    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_CHECK = 2'd2;

    typedef enum logic [2:0] {
        ST_LEGAL     = 3'd0,
        ST_ILLEGAL   = 3'd1,
        ST_OUT       = 3'd2,
        ST_MARKED    = 3'd3,
        ST_RANGE_OUT = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
    } in_item_t;

    typedef struct packed {
        status_t status;
        logic    allow_access;
    } out_item_t;

endpackage

/* hdl/heap_shadow_access_checker.sv */
// Heap shadow access checker: packed shadow memory with a word-at-a-time sequencer.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  cfg     | in        | cfg_wr_en            | cfg_wr_data = heap_base
//  s_      | in        | s_valid / s_ready    | s_data  (action, address, length)
//  m_      | out       | m_valid / m_ready    | m_data  (status, allow_access)
//
// Sequence: a check runs S_OFFS, S_RANGE (shadow read), S_CK_BIT and S_DONE (outside the heap
//   S_CK_BIT is skipped); a mark runs S_OFFS, S_RANGE, then one read and one write per word.
// Reset: after aresetn a clearing pass writes zero to all SHADOW_WORDS (2048) shadow
//   words, one per cycle; s_ready stays low until it ends. Config writes are taken.
// Stalls: one request at a time; a new request is taken while a result waits in the
//   output register, but the next result waits for that register to empty.
module heap_shadow_access_checker (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [hsac_pkg::ADDR_W-1:0] cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  hsac_pkg::in_item_t        s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output hsac_pkg::out_item_t       m_data
);
    import hsac_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,   // zeroing sweep after reset
        S_IDLE,    // waiting for a request
        S_OFFS,    // address minus heap base, heap bounds
        S_RANGE,   // range fit check, or shadow read for a check
        S_CK_BIT,  // pick the mark bit out of the read word
        S_MK_RD,   // read the shadow word being marked
        S_MK_WR,   // write it back with the range bits set or cleared
        S_DONE     // hand result to the output register
    } state_t;

    state_t              state_reg;
    logic [ADDR_W-1:0]   heap_base_reg;
    logic [WADDR_W-1:0]  clr_cnt_reg;
    logic [1:0]          act_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [OFF_W-1:0]    off_reg;
    logic                in_heap_reg;
    logic [WADDR_W-1:0]  word_reg;
    logic [WADDR_W-1:0]  first_w_reg;
    logic [WADDR_W-1:0]  last_w_reg;
    logic [BIT_W-1:0]    first_bit_reg;
    logic [BIT_W-1:0]    last_bit_reg;
    out_item_t           res_reg;
    logic                m_valid_reg;
    out_item_t           m_data_reg;

    // Shadow RAM: one write port, one registered read port.
    logic [MARKS_PER_WORD-1:0] shadow_mem [SHADOW_WORDS];
    logic [MARKS_PER_WORD-1:0] rd_data_reg;

    logic                      mem_wr_en;
    logic [WADDR_W-1:0]        mem_wr_addr;
    logic [MARKS_PER_WORD-1:0] mem_wr_data;
    logic                      mem_rd_en;
    logic [WADDR_W-1:0]        mem_rd_addr;

    logic                      is_check;
    logic                      is_alloc;
    logic [ADDR_W:0]           diff;
    logic                      in_heap_c;
    logic [END_W-1:0]          end_off;
    logic                      fits;
    logic [OFF_W-1:0]          last_off;
    logic [BIT_W-1:0]          word_lo;
    logic [BIT_W-1:0]          word_hi;
    logic [MARKS_PER_WORD-1:0] mask;
    logic                      out_free;

    assign is_check = act_reg[1];
    assign is_alloc = (act_reg == ACT_ALLOC);

    // Offset into the heap without wraparound: a borrow means below the base.
    assign diff      = {1'b0, addr_reg} - {1'b0, heap_base_reg};
    assign in_heap_c = !diff[ADDR_W] && (diff[ADDR_W-1:0] < ADDR_W'(HEAP_BYTES));

    // Range end (exclusive) must not pass the last heap byte.
    assign end_off  = END_W'(off_reg) + END_W'(len_reg);
    assign fits     = (end_off <= END_W'(HEAP_BYTES));
    assign last_off = OFF_W'(end_off - END_W'(1));

    // Bits of the current word that fall inside the range.
    assign word_lo = (word_reg == first_w_reg) ? first_bit_reg : '0;
    assign word_hi = (word_reg == last_w_reg) ? last_bit_reg : BIT_W'(MARKS_PER_WORD - 1);
    assign mask    = ({MARKS_PER_WORD{1'b1}} << word_lo)
                   & ({MARKS_PER_WORD{1'b1}} >> (BIT_W'(MARKS_PER_WORD - 1) - word_hi));

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        mem_wr_en   = (state_reg == S_CLEAR) || (state_reg == S_MK_WR);
        mem_wr_addr = (state_reg == S_CLEAR) ? clr_cnt_reg : word_reg;
        if (state_reg == S_CLEAR) begin
            mem_wr_data = '0;
        end else if (is_alloc) begin
            mem_wr_data = rd_data_reg | mask;
        end else begin
            mem_wr_data = rd_data_reg & ~mask;
        end
        mem_rd_en   = ((state_reg == S_RANGE) && is_check && in_heap_reg)
                    || (state_reg == S_MK_RD);
        mem_rd_addr = (state_reg == S_MK_RD) ? word_reg : WADDR_W'(off_reg >> BIT_W);
    end

    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            shadow_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            rd_data_reg <= shadow_mem[mem_rd_addr];
        end
    end

    // Config register lives outside the sequencer: writes land in any state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg <= '0;
        end else if (cfg_wr_en) begin
            heap_base_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // Output register: load a finished result, else drain on a transfer.
            if ((state_reg == S_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + WADDR_W'(1);
                    if (clr_cnt_reg == WADDR_W'(SHADOW_WORDS - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        act_reg   <= s_data.action;
                        addr_reg  <= s_data.address;
                        len_reg   <= s_data.length;
                        state_reg <= S_OFFS;
                    end
                end
                S_OFFS: begin
                    off_reg     <= diff[OFF_W-1:0];
                    in_heap_reg <= in_heap_c;
                    state_reg   <= S_RANGE;
                end
                S_RANGE: begin
                    res_reg.allow_access <= 1'b0;
                    if (is_check) begin
                        if (in_heap_reg) begin
                            state_reg <= S_CK_BIT;
                        end else begin
                            res_reg.status <= ST_OUT;
                            state_reg      <= S_DONE;
                        end
                    end else if (!in_heap_reg || !fits) begin
                        res_reg.status <= ST_RANGE_OUT;
                        state_reg      <= S_DONE;
                    end else if (len_reg == '0) begin
                        res_reg.status <= ST_MARKED;
                        state_reg      <= S_DONE;
                    end else begin
                        word_reg      <= WADDR_W'(off_reg >> BIT_W);
                        first_w_reg   <= WADDR_W'(off_reg >> BIT_W);
                        first_bit_reg <= off_reg[BIT_W-1:0];
                        last_w_reg    <= WADDR_W'(last_off >> BIT_W);
                        last_bit_reg  <= last_off[BIT_W-1:0];
                        state_reg     <= S_MK_RD;
                    end
                end
                S_CK_BIT: begin
                    if (rd_data_reg[off_reg[BIT_W-1:0]]) begin
                        res_reg.status       <= ST_LEGAL;
                        res_reg.allow_access <= 1'b1;
                    end else begin
                        res_reg.status       <= ST_ILLEGAL;
                        res_reg.allow_access <= 1'b0;
                    end
                    state_reg <= S_DONE;
                end
                S_MK_RD: begin
                    state_reg <= S_MK_WR;
                end
                S_MK_WR: begin
                    if (word_reg == last_w_reg) begin
                        res_reg.status <= ST_MARKED;
                        state_reg      <= S_DONE;
                    end else begin
                        word_reg  <= word_reg + WADDR_W'(1);
                        state_reg <= S_MK_RD;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        m_data_reg <= res_reg;
                        state_reg  <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Reset always starts the clearing pass, so no transfer right after it.
    a_reset_blocks: assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("s_ready high right after reset");

    // One request in flight: an input transfer drops ready.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready stayed high after an input transfer");

    // Access is allowed exactly for a legal check.
    a_allow_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.allow_access == (m_data.status == ST_LEGAL)))
        else $error("allow_access disagrees with status");

    // A mark sweep that reaches its last shadow word ends in a marked result.
    a_mark_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MK_WR) && (word_reg == last_w_reg)
        |=> (res_reg.status == ST_MARKED) && (state_reg == S_DONE))
        else $error("range sweep ended without a marked result");

endmodule
